/* rtl/core/lrt_pkg.sv */
// ----------------------------------------------------------------------------
// lrt_pkg: shared types, codes and helpers of the IPv4 route table
// Holds the field widths, the request and result codes, the table entry
// layout and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lrt_pkg;

  // Default number of table entries.
  localparam int DEF_TABLE_DEPTH = 16;

  // Field widths.
  localparam int ADDR_W     = 32;
  localparam int PLEN_W     = 6;
  localparam int IFACE_W    = 4;
  localparam int COST_W     = 32;
  localparam int INDEX_W    = 4;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 80;

  localparam logic [PLEN_W-1:0] HOST_LEN  = 6'd32;
  localparam logic [ADDR_W-1:0] FULL_MASK = 32'hFFFF_FFFF;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOOKUP    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEL_INDEX = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_IFACE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_NET   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] RES_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] RES_NO_ROUTE  = 3'd1;
  localparam logic [STATUS_W-1:0] RES_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] RES_DUP       = 3'd3;
  localparam logic [STATUS_W-1:0] RES_BAD_INDEX = 3'd4;

  // One table entry as held in the table memory.
  typedef struct packed {
    logic [ADDR_W-1:0]  net;
    logic [PLEN_W-1:0]  plen;
    logic [ADDR_W-1:0]  gw;
    logic [IFACE_W-1:0] iface;
    logic [COST_W-1:0]  cost;
  } lrt_entry_t;

  // One request as taken from the input channel.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  addr;
    logic [PLEN_W-1:0]  plen;
    logic [ADDR_W-1:0]  gw;
    logic [IFACE_W-1:0] iface;
    logic [COST_W-1:0]  cost;
    logic [INDEX_W-1:0] index;
    logic               use_filter;
    logic [IFACE_W-1:0] filter_iface;
  } lrt_req_t;

  // One result as handed to the output channel.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   hit_network;
    logic [ADDR_W-1:0]   hit_gateway;
    logic [IFACE_W-1:0]  hit_iface;
    logic [COUNT_W-1:0]  removed_count;
    logic [COUNT_W-1:0]  entries_used;
  } lrt_resp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } lrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } lrt_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } lrt_state_t;

  // Prefix lengths above a host route count as a host route.
  function automatic logic [PLEN_W-1:0] clamp_len(input logic [PLEN_W-1:0] len);
    return (len > HOST_LEN) ? HOST_LEN : len;
  endfunction

  // Network mask for a prefix length of at most a host route.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [PLEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = FULL_MASK << (HOST_LEN - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lpm_route_table.sv */
// A result is registered once the scan over the N entries held has ended; a host
// route hit in a lookup or a duplicate in an add ends the scan sooner.
// The scan reads one entry per cycle. A new request is taken only after the last
// result went to the output register; a result waiting there delays that handover.
// Reset clears the fill count and the handshake state; the table memory is
// not cleared, entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
// lpm_route_table: IPv4 longest prefix match route table
// Stream request in, one result per request out. Lookups, adds and
// compacting removals run as an ordered scan over the table.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_route_table #(
  parameter int TABLE_DEPTH = lrt_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata, from the lowest bit: address[31:0], prefix_len[37:32],
  // gateway[69:38], iface[73:70], route_cost[105:74], entry_index[109:106],
  // use_filter[110], filter_iface[114:111], zero fill up to 120 bits.
  input  wire logic [lrt_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode[2:0].
  input  wire logic [lrt_pkg::MODE_W-1:0]     in_tuser,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // out_tdata, from the lowest bit: hit_network[31:0], hit_gateway[63:32],
  // hit_iface[67:64], removed_count[72:68], entries_used[77:73],
  // zero fill up to 80 bits.
  output logic [lrt_pkg::OUT_DATA_W-1:0]     out_tdata,
  // out_tuser: status[2:0].
  output logic [lrt_pkg::STATUS_W-1:0]       out_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready
);

  import lrt_pkg::*;

  lrt_req_t  req;
  lrt_resp_t resp;
  lrt_cmd_t  cmd;
  lrt_stat_t stat;

  // Request fields out of the input transfer.
  assign req.mode         = in_tuser;
  assign req.addr         = in_tdata[31:0];
  assign req.plen         = in_tdata[37:32];
  assign req.gw           = in_tdata[69:38];
  assign req.iface        = in_tdata[73:70];
  assign req.cost         = in_tdata[105:74];
  assign req.index        = in_tdata[109:106];
  assign req.use_filter   = in_tdata[110];
  assign req.filter_iface = in_tdata[114:111];

  lrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lrt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req),
    .cmd    (cmd),
    .stat   (stat),
    .resp   (resp)
  );

  // Result fields into the output transfer.
  assign out_tuser = resp.status;
  assign out_tdata = {2'b00, resp.entries_used, resp.removed_count,
                      resp.hit_iface, resp.hit_gateway, resp.hit_network};

endmodule

`default_nettype wire

/* rtl/core/lrt_ctrl.sv */
// ----------------------------------------------------------------------------
// lrt_ctrl: sequencing controller of the route table
// Takes one request, steps the datapath through the table scan and hands
// the result to the output register once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire lrt_pkg::lrt_stat_t stat,
  output lrt_pkg::lrt_cmd_t      cmd
);

  import lrt_pkg::*;

  lrt_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_free   = !out_valid_r || out_tready;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_done) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register fills on finish and empties on a transfer.
  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  // Waiting for the output register only happens while it holds a result.
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD) |-> out_valid_r)
    else $error("hold state entered with an empty output register");

  // A result is only written once the scan has ended.
  a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> stat.scan_done)
    else $error("finish issued before the scan ended");

  // Every finish leaves a result waiting at the output.
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finish did not present a result");

endmodule

`default_nettype wire

/* rtl/core/lrt_datapath.sv */
// ----------------------------------------------------------------------------
// lrt_datapath: table memory, scan engine and result register
// Scans the table one entry per cycle through a registered read port,
// keeps the best match, detects duplicates and compacts on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_datapath #(
  parameter int TABLE_DEPTH = lrt_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lrt_pkg::lrt_req_t  in_req,
  input  wire lrt_pkg::lrt_cmd_t  cmd,
  output lrt_pkg::lrt_stat_t     stat,
  output lrt_pkg::lrt_resp_t     resp
);

  import lrt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Table memory and its registered read data.
  lrt_entry_t mem [TABLE_DEPTH];
  lrt_entry_t mem_q;

  // Control state.
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] rd_cnt_r;
  logic [CW-1:0] wptr_r;
  logic          pend_vld_r;
  logic          stop_r;
  logic          found_r;
  logic          dup_r;

  // Request and running match registers.
  lrt_req_t          req_r, req_nxt;
  logic [ADDR_W-1:0] netw_r;
  logic [AW-1:0]     pend_idx_r;
  logic [PLEN_W-1:0] best_len_r;
  logic [COST_W-1:0] best_cost_r;
  logic [ADDR_W-1:0] hit_net_r;
  logic [ADDR_W-1:0] hit_gw_r;
  logic [IFACE_W-1:0] hit_ifc_r;
  lrt_resp_t         resp_r, resp_nxt;

  logic              rd_en;
  logic              more;
  logic              proc;
  logic [ADDR_W-1:0] e_mask;
  logic              lk_take;
  logic              is_dup;
  logic              is_remove;
  logic              drop;
  logic              add_ok;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  lrt_entry_t        wr_data;
  lrt_entry_t        new_entry;

  // Scan progress.
  assign more  = rd_cnt_r < fill_r;
  assign rd_en = cmd.step && !stop_r && more;
  assign proc  = cmd.step && pend_vld_r && !stop_r;
  assign stat.scan_done = stop_r || (!pend_vld_r && !more);

  // Lookup: longest prefix, then lowest cost, a later equal entry wins.
  assign e_mask  = len_mask(mem_q.plen);
  assign lk_take = ((req_r.addr & e_mask) == (mem_q.net & e_mask)) &&
                   (!req_r.use_filter || (mem_q.iface == req_r.filter_iface)) &&
                   ((mem_q.plen > best_len_r) ||
                    ((mem_q.plen == best_len_r) && (mem_q.cost <= best_cost_r)));

  assign new_entry.net   = req_r.addr;
  assign new_entry.plen  = req_r.plen;
  assign new_entry.gw    = req_r.gw;
  assign new_entry.iface = req_r.iface;
  assign new_entry.cost  = req_r.cost;
  assign is_dup = (mem_q == new_entry);

  // Removal decision for the entry at hand.
  always_comb begin
    is_remove = 1'b0;
    drop      = 1'b0;
    unique case (req_r.mode)
      MODE_DEL_INDEX: begin
        is_remove = 1'b1;
        drop      = (XW'(pend_idx_r) == XW'(req_r.index));
      end
      MODE_DEL_IFACE: begin
        is_remove = 1'b1;
        drop      = (mem_q.iface == req_r.iface);
      end
      MODE_DEL_NET: begin
        is_remove = 1'b1;
        drop      = (mem_q.iface == req_r.iface) && (mem_q.plen != HOST_LEN) &&
                    (mem_q.net == netw_r) && (mem_q.plen == req_r.plen);
      end
      default: begin
        is_remove = 1'b0;
      end
    endcase
  end

  assign add_ok = (req_r.mode == MODE_ADD) && !dup_r && (fill_r != DEPTH_C);

  // Memory write: kept entries move down during a removal, an add appends.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr_r[AW-1:0];
    wr_data = mem_q;
    if (proc && is_remove && !drop) begin
      wr_en = 1'b1;
    end else if (cmd.finish && add_ok) begin
      wr_en   = 1'b1;
      wr_addr = fill_r[AW-1:0];
      wr_data = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_cnt_r[AW-1:0]];
    end
  end

  // Result of the finished item.
  always_comb begin
    fill_nxt        = fill_r;
    resp_nxt        = '0;
    resp_nxt.status = RES_OK;
    unique case (req_r.mode)
      MODE_LOOKUP: begin
        resp_nxt.status      = found_r ? RES_OK : RES_NO_ROUTE;
        resp_nxt.hit_network = hit_net_r;
        resp_nxt.hit_gateway = hit_gw_r;
        resp_nxt.hit_iface   = hit_ifc_r;
      end
      MODE_ADD: begin
        if (dup_r) begin
          resp_nxt.status = RES_DUP;
        end else if (fill_r == DEPTH_C) begin
          resp_nxt.status = RES_FULL;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      MODE_DEL_INDEX: begin
        if (XW'(req_r.index) >= XW'(fill_r)) begin
          resp_nxt.status = RES_BAD_INDEX;
        end else begin
          fill_nxt               = wptr_r;
          resp_nxt.removed_count = COUNT_W'(fill_r - wptr_r);
        end
      end
      MODE_DEL_IFACE: begin
        fill_nxt               = wptr_r;
        resp_nxt.removed_count = COUNT_W'(fill_r - wptr_r);
      end
      MODE_DEL_NET: begin
        fill_nxt               = wptr_r;
        resp_nxt.removed_count = COUNT_W'(fill_r - wptr_r);
      end
      default: begin
        fill_nxt = fill_r;
      end
    endcase
    resp_nxt.entries_used = COUNT_W'(fill_nxt);
  end

  // The request is held with its prefix length already clamped.
  always_comb begin
    req_nxt      = in_req;
    req_nxt.plen = clamp_len(in_req.plen);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      rd_cnt_r   <= '0;
      wptr_r     <= '0;
      pend_vld_r <= 1'b0;
      stop_r     <= 1'b0;
      found_r    <= 1'b0;
      dup_r      <= 1'b0;
    end else if (cmd.load) begin
      rd_cnt_r   <= '0;
      wptr_r     <= '0;
      pend_vld_r <= 1'b0;
      stop_r     <= 1'b0;
      found_r    <= 1'b0;
      dup_r      <= 1'b0;
    end else begin
      if (cmd.step) begin
        pend_vld_r <= rd_en;
        if (rd_en) begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
        end
      end
      if (proc) begin
        if (req_r.mode == MODE_LOOKUP && lk_take) begin
          found_r <= 1'b1;
          if (mem_q.plen == HOST_LEN) begin
            stop_r <= 1'b1;
          end
        end
        if (req_r.mode == MODE_ADD && is_dup) begin
          dup_r  <= 1'b1;
          stop_r <= 1'b1;
        end
        if (is_remove && !drop) begin
          wptr_r <= wptr_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= req_nxt;
      netw_r      <= in_req.addr & len_mask(req_nxt.plen);
      best_len_r  <= '0;
      best_cost_r <= FULL_MASK;
      hit_net_r   <= '0;
      hit_gw_r    <= '0;
      hit_ifc_r   <= '0;
    end else if (proc && req_r.mode == MODE_LOOKUP && lk_take) begin
      best_len_r  <= mem_q.plen;
      best_cost_r <= mem_q.cost;
      hit_net_r   <= mem_q.net;
      hit_gw_r    <= mem_q.gw;
      hit_ifc_r   <= mem_q.iface;
    end
    if (cmd.step) begin
      pend_idx_r <= rd_cnt_r[AW-1:0];
    end
    if (cmd.finish) begin
      resp_r <= resp_nxt;
    end
  end

  assign resp = resp_r;

  // The table never holds more entries than it has room for.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("fill count above table depth");

  // Compaction never writes ahead of what has been read.
  a_wptr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    wptr_r <= rd_cnt_r)
    else $error("compaction write pointer passed the read pointer");

  // Only filled entries are ever examined.
  a_pend_filled: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (CW'(pend_idx_r) < fill_r))
    else $error("scan examined an entry beyond the fill count");

  // An early stop only ends a lookup or an add.
  a_stop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> (req_r.mode == MODE_LOOKUP || req_r.mode == MODE_ADD))
    else $error("early stop during a removal");

endmodule

`default_nettype wire

/* tb/tb_lpm_route_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lpm_route_table: self-checking bench for the IPv4 longest prefix route table
// Requests go in as stream transfers and every result transfer is checked
// against a behavioural copy of the table kept in the bench (typed directed rows
// carry their own expected result). A short directed table covers the corner
// cases. Random traffic follows: fill bursts, duplicate adds, lookups aimed at
// stored routes and the three removals. Both channels are throttled in turn,
// and long back-pressure stretches fill the block up.
// ----------------------------------------------------------------------------

module tb_lpm_route_table;
  import lrt_pkg::*;

  localparam int TBL_DEPTH      = DEF_TABLE_DEPTH;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = TBL_DEPTH + 8;
  localparam int MAX_REPORTS    = 10;

  // Modes with no defined action; the block must leave the table alone.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam bit CHK  = 1'b1;
  localparam bit PRED = 1'b0;

  typedef enum {
    K_ADD, K_DUP, K_LOOKUP, K_DEL_INDEX, K_DEL_IFACE, K_DEL_NET, K_NOISE
  } req_kind_t;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct {
    lrt_req_t  rq;
    bit        typed;
    lrt_resp_t res;
  } route_case_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // Bench copy of the table.
  lrt_entry_t  route_tbl [TBL_DEPTH];
  int unsigned route_fill = 0;

  lrt_resp_t route_expect_q [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_req_cnt = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int mode_count [8];
  int status_count [8];

  lpm_route_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Network mask with the top len bits set; lengths past a host route give all ones.
  function automatic logic [ADDR_W-1:0] prefix_to_mask(input logic [PLEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int b = 0; b < ADDR_W; b++) begin
      if (b >= ADDR_W - int'(len)) m[b] = 1'b1;
    end
    return m;
  endfunction

  // Applies one request to the bench table and works out the result it gives.
  task automatic route_table_apply(input lrt_req_t rq, output lrt_resp_t rs);
    logic [PLEN_W-1:0] plen;
    logic [PLEN_W-1:0] best_len;
    logic [COST_W-1:0] best_cost;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] netw;
    lrt_entry_t        cand;
    bit                found;
    bit                dup;
    bit                drop [TBL_DEPTH];
    int                w;

    plen = (rq.plen > HOST_LEN) ? HOST_LEN : rq.plen;
    rs = '0;
    rs.status = RES_OK;
    for (int i = 0; i < TBL_DEPTH; i++) drop[i] = 1'b0;

    case (rq.mode)
      MODE_LOOKUP: begin
        // Longest prefix wins, then lowest cost, a later tie replaces an
        // earlier one, and the first matching host route ends the scan.
        found = 1'b0;
        best_len = '0;
        best_cost = FULL_MASK;
        for (int i = 0; i < route_fill; i++) begin
          mask = prefix_to_mask(route_tbl[i].plen);
          if ((rq.addr & mask) != (route_tbl[i].net & mask)) continue;
          if (rq.use_filter && route_tbl[i].iface != rq.filter_iface) continue;
          if (route_tbl[i].plen < best_len) continue;
          if (route_tbl[i].plen > best_len) best_cost = FULL_MASK;
          best_len = route_tbl[i].plen;
          if (route_tbl[i].cost > best_cost) continue;
          best_cost = route_tbl[i].cost;
          found = 1'b1;
          rs.hit_network = route_tbl[i].net;
          rs.hit_gateway = route_tbl[i].gw;
          rs.hit_iface = route_tbl[i].iface;
          if (route_tbl[i].plen == HOST_LEN) break;
        end
        if (!found) rs.status = RES_NO_ROUTE;
      end
      MODE_ADD: begin
        // The duplicate check comes before the full check.
        cand = '{net: rq.addr, plen: plen, gw: rq.gw, iface: rq.iface, cost: rq.cost};
        dup = 1'b0;
        for (int i = 0; i < route_fill; i++) begin
          if (route_tbl[i] == cand) begin
            dup = 1'b1;
            break;
          end
        end
        if (dup) begin
          rs.status = RES_DUP;
        end else if (route_fill >= TBL_DEPTH) begin
          rs.status = RES_FULL;
        end else begin
          route_tbl[route_fill] = cand;
          route_fill++;
        end
      end
      MODE_DEL_INDEX: begin
        if (rq.index >= route_fill) rs.status = RES_BAD_INDEX;
        else drop[rq.index] = 1'b1;
      end
      MODE_DEL_IFACE: begin
        for (int i = 0; i < route_fill; i++) drop[i] = (route_tbl[i].iface == rq.iface);
      end
      MODE_DEL_NET: begin
        // Host routes are never taken out by a network removal.
        netw = rq.addr & prefix_to_mask(plen);
        for (int i = 0; i < route_fill; i++) begin
          drop[i] = route_tbl[i].iface == rq.iface && route_tbl[i].plen != HOST_LEN &&
                    route_tbl[i].net == netw && route_tbl[i].plen == plen;
        end
      end
      default: begin
      end
    endcase

    // Compaction keeps the order of the surviving entries.
    w = 0;
    for (int r = 0; r < route_fill; r++) begin
      if (!drop[r]) begin
        route_tbl[w] = route_tbl[r];
        w++;
      end
    end
    rs.removed_count = COUNT_W'(route_fill - w);
    route_fill = w;
    rs.entries_used = COUNT_W'(route_fill);
  endtask

  function automatic route_case_t dir_row(
    input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
    input logic [PLEN_W-1:0] plen, input logic [ADDR_W-1:0] gw,
    input logic [IFACE_W-1:0] iface, input logic [COST_W-1:0] cost,
    input logic [INDEX_W-1:0] index, input logic filt, input logic [IFACE_W-1:0] fifc,
    input bit typed, input logic [STATUS_W-1:0] st, input logic [COUNT_W-1:0] used);
    route_case_t c;
    c.rq = '{mode: mode, addr: addr, plen: plen, gw: gw, iface: iface, cost: cost,
             index: index, use_filter: filt, filter_iface: fifc};
    c.typed = typed;
    c.res = '0;
    c.res.status = st;
    c.res.entries_used = used;
    return c;
  endfunction

  // Random request of the given kind; fields the mode ignores carry noise.
  function automatic lrt_req_t make_request(input req_kind_t kind);
    lrt_req_t          rq;
    lrt_entry_t        e;
    logic [ADDR_W-1:0] m;
    logic [7:0]        top;

    rq.mode = MODE_W'($urandom_range(MODE_LOOKUP, MODE_SPARE_HI));
    rq.addr = $urandom;
    rq.plen = PLEN_W'($urandom_range(0, 63));
    rq.gw = $urandom;
    rq.iface = IFACE_W'($urandom_range(0, 15));
    rq.cost = $urandom;
    rq.index = INDEX_W'($urandom_range(0, 15));
    rq.use_filter = 1'($urandom_range(0, 1));
    rq.filter_iface = IFACE_W'($urandom_range(0, 15));
    e = '0;
    if (route_fill > 0) e = route_tbl[$urandom_range(0, route_fill - 1)];
    m = prefix_to_mask(e.plen);

    case (kind)
      K_ADD: begin
        // Few distinct networks and costs, so that matches and ties are common.
        rq.mode = MODE_ADD;
        case ($urandom_range(0, 9))
          0:       rq.plen = PLEN_W'($urandom_range(33, 63));
          1, 2:    rq.plen = HOST_LEN;
          3:       rq.plen = '0;
          4, 5:    rq.plen = PLEN_W'(8 * $urandom_range(1, 3));
          default: rq.plen = PLEN_W'($urandom_range(1, 31));
        endcase
        case ($urandom_range(0, 3))
          0:       top = 8'd10;
          1:       top = 8'd172;
          2:       top = 8'd192;
          default: top = 8'($urandom);
        endcase
        rq.addr = {top, 8'($urandom_range(0, 2)), 16'($urandom)};
        if ($urandom_range(0, 4) != 0) rq.addr &= prefix_to_mask(rq.plen);
        if ($urandom_range(0, 4) != 0) rq.iface = IFACE_W'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0:       rq.cost = FULL_MASK;
          1, 2:    rq.cost = $urandom;
          default: rq.cost = $urandom_range(0, 3);
        endcase
      end
      K_DUP: begin
        rq.mode = MODE_ADD;
        if (route_fill > 0) begin
          rq.addr = e.net;
          rq.plen = (e.plen == HOST_LEN && $urandom_range(0, 1)) ?
                    PLEN_W'($urandom_range(33, 63)) : e.plen;
          rq.gw = e.gw;
          rq.iface = e.iface;
          rq.cost = e.cost;
        end
      end
      K_LOOKUP: begin
        rq.mode = MODE_LOOKUP;
        if (route_fill > 0 && $urandom_range(0, 3) != 0) begin
          rq.addr = (e.net & m) | (rq.addr & ~m);
        end
        if ($urandom_range(0, 1)) rq.filter_iface = e.iface;
      end
      K_DEL_INDEX: begin
        rq.mode = MODE_DEL_INDEX;
        if ($urandom_range(0, 1)) rq.index = INDEX_W'($urandom_range(0, route_fill));
      end
      K_DEL_IFACE: begin
        rq.mode = MODE_DEL_IFACE;
        rq.iface = $urandom_range(0, 1) ? e.iface : 4'($urandom_range(0, 3));
      end
      K_DEL_NET: begin
        rq.mode = MODE_DEL_NET;
        if (route_fill > 0 && $urandom_range(0, 4) != 0) begin
          rq.addr = (e.net & m) | (rq.addr & ~m);
          rq.plen = (e.plen == HOST_LEN) ? PLEN_W'($urandom_range(32, 63)) : e.plen;
          if ($urandom_range(0, 4) != 0) rq.iface = e.iface;
        end
      end
      default: begin
      end
    endcase
    return rq;
  endfunction

  // Offers one request, waits for its transfer, then records what it should give.
  task automatic send_request(input lrt_req_t rq, input bit typed, input lrt_resp_t typed_res);
    lrt_resp_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {5'b0, rq.filter_iface, rq.use_filter, rq.index, rq.cost, rq.iface,
                  rq.gw, rq.plen, rq.addr};
    in_tuser  <= rq.mode;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    route_table_apply(rq, predicted);
    route_expect_q.push_back(typed ? typed_res : predicted);
    mode_count[rq.mode]++;
    status_count[predicted.status]++;
    items_sent++;
  endtask

  // Stops offering and waits until every outstanding result has arrived.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (route_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string what, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                 results_checked, what, want, got);
      end
    end
  endtask

  // Result side: random back-pressure, plus a long hold-off when asked.
  initial begin : result_sink
    int seen_req;
    int hold_left;
    seen_req = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (stall_req_cnt != seen_req) begin
        seen_req = stall_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    lrt_resp_t got;
    lrt_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status        = out_tuser;
      got.hit_network   = out_tdata[31:0];
      got.hit_gateway   = out_tdata[63:32];
      got.hit_iface     = out_tdata[67:64];
      got.removed_count = out_tdata[72:68];
      got.entries_used  = out_tdata[77:73];
      if (route_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("MISMATCH unexpected result, status %0d", got.status);
        end
      end else begin
        want = route_expect_q.pop_front();
        compare_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
        compare_field("hit_network", want.hit_network, got.hit_network);
        compare_field("hit_gateway", want.hit_gateway, got.hit_gateway);
        compare_field("hit_iface", ADDR_W'(want.hit_iface), ADDR_W'(got.hit_iface));
        compare_field("removed_count", ADDR_W'(want.removed_count),
                      ADDR_W'(got.removed_count));
        compare_field("entries_used", ADDR_W'(want.entries_used),
                      ADDR_W'(got.entries_used));
      end
      results_checked++;
    end
  end

  // Watchdog: ends the run after too long without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lpm_route_table verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin : stimulus
    route_case_t dir_cases [$];
    int          phase_end [3];
    int          tries;

    phase_end[0] = 300;
    phase_end[1] = 575;
    phase_end[2] = 850;
    for (int i = 0; i < 8; i++) begin
      mode_count[i] = 0;
      status_count[i] = 0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: empty table, default route, duplicates, prefix clamping,
    // cost ties, filtered lookups, host routes and every removal.
    dir_cases.push_back(dir_row(MODE_LOOKUP, 32'h0a01_0203, 0, 0, 0, 0, 0, 0, 0,
                                CHK, RES_NO_ROUTE, 0));
    dir_cases.push_back(dir_row(MODE_DEL_INDEX, 0, 0, 0, 0, 0, 0, 0, 0,
                                CHK, RES_BAD_INDEX, 0));
    dir_cases.push_back(dir_row(MODE_DEL_IFACE, 0, 0, 0, 0, 0, 0, 0, 0, CHK, RES_OK, 0));
    dir_cases.push_back(dir_row(MODE_ADD, 32'h0, 0, 32'h0a00_0001, 0, FULL_MASK, 0, 0, 0,
                                CHK, RES_OK, 1));
    dir_cases.push_back(dir_row(MODE_ADD, 32'h0, 0, 32'h0a00_0001, 0, FULL_MASK, 0, 0, 0,
                                CHK, RES_DUP, 1));
    dir_cases.push_back(dir_row(MODE_ADD, 32'h0a00_0000, 8, 32'h0a00_0002, 1, 5, 0, 0, 0,
                                CHK, RES_OK, 2));
    dir_cases.push_back(dir_row(MODE_ADD, 32'h0a00_0000, 8, 32'h0a00_0009, 4, 7, 0, 0, 0,
                                CHK, RES_OK, 3));
    dir_cases.push_back(dir_row(MODE_ADD, 32'h0a01_0000, 16, 32'h0a00_0003, 2, 10, 0, 0, 0,
                                CHK, RES_OK, 4));
    dir_cases.push_back(dir_row(MODE_ADD, 32'h0a01_0000, 16, 32'h0a00_0004, 3, 10, 0, 0, 0,
                                CHK, RES_OK, 5));
    dir_cases.push_back(dir_row(MODE_ADD, 32'h0a01_0203, 63, 0, 15, 0, 0, 0, 0,
                                CHK, RES_OK, 6));
    dir_cases.push_back(dir_row(MODE_ADD, 32'h0a01_0203, 32, 0, 15, 0, 0, 0, 0,
                                CHK, RES_DUP, 6));
    dir_cases.push_back(dir_row(MODE_ADD, FULL_MASK, 32, FULL_MASK, 15, FULL_MASK, 0, 0, 0,
                                CHK, RES_OK, 7));
    dir_cases.push_back(dir_row(MODE_LOOKUP, 32'h0a05_0505, 0, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_LOOKUP, 32'h0a01_0203, 0, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_LOOKUP, 32'h0a01_0909, 0, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_LOOKUP, 32'h0a01_0909, 0, 0, 0, 0, 0, 1, 2, PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_LOOKUP, 32'hc0a8_0101, 0, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_LOOKUP, 32'h0a01_0909, 0, 0, 0, 0, 0, 1, 9, PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_LOOKUP, FULL_MASK, 0, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_DEL_NET, 32'h0a01_0707, 16, 0, 3, 0, 0, 0, 0,
                                PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_DEL_NET, 32'h0a01_0203, 63, 0, 15, 0, 0, 0, 0,
                                PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_SPARE_HI, FULL_MASK, 63, FULL_MASK, 15, FULL_MASK, 15, 1,
                                15, PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_DEL_INDEX, 0, 0, 0, 0, 0, 15, 0, 0,
                                CHK, RES_BAD_INDEX, 6));
    dir_cases.push_back(dir_row(MODE_DEL_IFACE, 0, 0, 0, 15, 0, 0, 0, 0, PRED, 0, 0));
    dir_cases.push_back(dir_row(MODE_DEL_INDEX, 0, 0, 0, 0, 0, 0, 0, 0, PRED, 0, 0));

    foreach (dir_cases[i]) send_request(dir_cases[i].rq, dir_cases[i].typed, dir_cases[i].res);
    drain_results();

    // Random traffic in three throttling phases; each later phase opens with a
    // long result hold-off while requests keep coming.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct = 73;
        end
        1: begin
          tx_idle_pct = 73;
          rx_idle_pct = 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph > 0) stall_req_cnt <= stall_req_cnt + 1;
      while (items_sent < phase_end[ph]) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            // Fill to the brim, then try once more on the full table.
            tries = 0;
            while (route_fill < TBL_DEPTH && tries < 40) begin
              send_request(make_request(K_ADD), PRED, '0);
              tries++;
            end
            send_request(make_request(K_ADD), PRED, '0);
            send_request(make_request(K_DUP), PRED, '0);
          end
          2, 3, 4: begin
            repeat ($urandom_range(3, 10)) send_request(make_request(K_LOOKUP), PRED, '0);
          end
          5: begin
            repeat ($urandom_range(1, 3)) send_request(make_request(K_DEL_INDEX), PRED, '0);
          end
          6: begin
            send_request(make_request(K_DEL_IFACE), PRED, '0);
          end
          7: begin
            send_request(make_request(K_DEL_NET), PRED, '0);
            send_request(make_request(K_LOOKUP), PRED, '0);
          end
          8: begin
            send_request(make_request(K_DUP), PRED, '0);
            send_request(make_request(K_ADD), PRED, '0);
          end
          default: begin
            repeat (2) send_request(make_request(K_NOISE), PRED, '0);
          end
        endcase
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d lookups, %0d adds, ",
             items_sent, mode_count[MODE_LOOKUP], mode_count[MODE_ADD],
             "%0d index, %0d interface and %0d network removals, ",
             mode_count[MODE_DEL_INDEX], mode_count[MODE_DEL_IFACE], mode_count[MODE_DEL_NET],
             "%0d spare-mode requests.",
             mode_count[MODE_SPARE_LO] + mode_count[MODE_SPARE_LO + 1] +
             mode_count[MODE_SPARE_HI]);
    $display("Outcomes: %0d misses, %0d table full, %0d duplicates, %0d bad indexes; ",
             status_count[RES_NO_ROUTE], status_count[RES_FULL], status_count[RES_DUP],
             status_count[RES_BAD_INDEX],
             "%0d results checked, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("lpm_route_table verification clean");
    end else begin
      $display("lpm_route_table verification failed");
    end
    $finish;
  end

endmodule
